@@ src/rmq_pkg.sv @@
// Shared types, constants and step functions for the matrix-to-quaternion pipeline.
`timescale 1ns / 1ps
package rmq_pkg;

    // Field format
    localparam int DATA_W    = 16;
    localparam int FRAC      = DATA_W - 2;
    localparam int CAND_W    = DATA_W + 2;
    localparam int MAG_W     = DATA_W + 1;
    localparam int LANES     = 4;

    // Square root unit: 34-bit radicand, one root bit per stage
    localparam int RAD_W     = 2 * MAG_W;
    localparam int ROOT_W    = MAG_W;
    localparam int SQ_STEPS  = ROOT_W;
    localparam int SQ_REM_W  = ROOT_W + 2;

    // Divider: 34-bit dividend, top part preloaded, one quotient bit per stage
    localparam int DVD_W     = RAD_W;
    localparam int DIV_STEPS = MAG_W;

    // Largest-candidate codes
    localparam logic [1:0] SEL_W = 2'd0;
    localparam logic [1:0] SEL_X = 2'd1;
    localparam logic [1:0] SEL_Y = 2'd2;
    localparam logic [1:0] SEL_Z = 2'd3;

    // Sideband that travels with each item through the arithmetic units
    typedef struct packed {
        logic [1:0]                    sel;
        logic [MAG_W-1:0]              aux;
        logic [LANES-1:0]              neg;
        logic [LANES-1:0][MAG_W-1:0]   mag;
    } t_side;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
    } t_sq;

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic             q;
    } t_dv;

    // One digit of the restoring square root
    function automatic t_sq sq_step(input logic [SQ_REM_W-1:0] rem,
                                    input logic [ROOT_W-1:0]   root,
                                    input logic [1:0]          d);
        logic [SQ_REM_W+1:0] t;
        logic [SQ_REM_W+1:0] b;
        t_sq                 r;
        t = {rem, d};
        b = {2'b00, root, 2'b01};
        if (t >= b) begin
            r.rem  = SQ_REM_W'(t - b);
            r.root = {root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = t[SQ_REM_W-1:0];
            r.root = {root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // One bit of the restoring division
    function automatic t_dv div_step(input logic [MAG_W-1:0] rem,
                                     input logic             b,
                                     input logic [MAG_W-1:0] den);
        logic [MAG_W:0] t;
        t_dv            r;
        t = {rem, b};
        if (t >= {1'b0, den}) begin
            r.rem = MAG_W'(t - {1'b0, den});
            r.q   = 1'b1;
        end else begin
            r.rem = t[MAG_W-1:0];
            r.q   = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ src/rmq_front.sv @@
// Front end: diagonal candidates, largest pick, off-diagonal pairs and radicand.
`timescale 1ns / 1ps
module rmq_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_e_xx,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_e_xy,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_e_xz,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_e_yx,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_e_yy,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_e_yz,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_e_zx,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_e_zy,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_e_zz,
    output logic                               o_valid,
    output logic [rmq_pkg::RAD_W-1:0]          o_rad,
    output rmq_pkg::t_side                     o_side
);
    import rmq_pkg::*;

    localparam int P_YZ_M = 0;
    localparam int P_ZX_M = 1;
    localparam int P_XY_M = 2;
    localparam int P_XY_P = 3;
    localparam int P_ZX_P = 4;
    localparam int P_YZ_P = 5;
    localparam int NPAIR  = 6;

    logic signed [CAND_W-1:0] cand [LANES];
    logic signed [CAND_W-1:0] best;
    logic [1:0]               sel;
    logic signed [CAND_W-1:0] n_a_pair [NPAIR];

    logic                     r_a_vld;
    logic [1:0]               r_a_sel;
    logic [MAG_W-1:0]         r_a_best;
    logic signed [CAND_W-1:0] r_a_pair [NPAIR];

    logic signed [CAND_W-1:0] lane_p [LANES-1];
    logic [MAG_W-1:0]         rad;
    t_side                    n_b_side;

    logic                     r_b_vld;
    logic [RAD_W-1:0]         r_b_rad;
    t_side                    r_b_side;

    // Form candidates and pick the largest, earlier wins ties
    always_comb begin
        cand[0] = CAND_W'(i_e_xx) + CAND_W'(i_e_yy) + CAND_W'(i_e_zz);
        cand[1] = CAND_W'(i_e_xx) - CAND_W'(i_e_yy) - CAND_W'(i_e_zz);
        cand[2] = CAND_W'(i_e_yy) - CAND_W'(i_e_xx) - CAND_W'(i_e_zz);
        cand[3] = CAND_W'(i_e_zz) - CAND_W'(i_e_xx) - CAND_W'(i_e_yy);
        best = cand[0];
        sel  = SEL_W;
        for (int i = 1; i < LANES; i++) begin
            if (cand[i] > best) begin
                best = cand[i];
                sel  = 2'(i);
            end
        end
        n_a_pair[P_YZ_M] = CAND_W'(i_e_yz) - CAND_W'(i_e_zy);
        n_a_pair[P_ZX_M] = CAND_W'(i_e_zx) - CAND_W'(i_e_xz);
        n_a_pair[P_XY_M] = CAND_W'(i_e_xy) - CAND_W'(i_e_yx);
        n_a_pair[P_XY_P] = CAND_W'(i_e_xy) + CAND_W'(i_e_yx);
        n_a_pair[P_ZX_P] = CAND_W'(i_e_zx) + CAND_W'(i_e_xz);
        n_a_pair[P_YZ_P] = CAND_W'(i_e_yz) + CAND_W'(i_e_zy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_sel  <= sel;
            r_a_best <= best[MAG_W-1:0];
            for (int i = 0; i < NPAIR; i++) begin
                r_a_pair[i] <= n_a_pair[i];
            end
        end
    end

    // Route the pairs to lanes, split sign and magnitude, build the radicand
    always_comb begin
        case (r_a_sel)
            SEL_W: begin
                lane_p[0] = r_a_pair[P_YZ_M];
                lane_p[1] = r_a_pair[P_ZX_M];
                lane_p[2] = r_a_pair[P_XY_M];
            end
            SEL_X: begin
                lane_p[0] = r_a_pair[P_YZ_M];
                lane_p[1] = r_a_pair[P_XY_P];
                lane_p[2] = r_a_pair[P_ZX_P];
            end
            SEL_Y: begin
                lane_p[0] = r_a_pair[P_ZX_M];
                lane_p[1] = r_a_pair[P_XY_P];
                lane_p[2] = r_a_pair[P_YZ_P];
            end
            default: begin
                lane_p[0] = r_a_pair[P_XY_M];
                lane_p[1] = r_a_pair[P_ZX_P];
                lane_p[2] = r_a_pair[P_YZ_P];
            end
        endcase
        n_b_side     = '0;
        n_b_side.sel = r_a_sel;
        for (int l = 0; l < LANES - 1; l++) begin
            n_b_side.neg[l] = lane_p[l][CAND_W-1];
            n_b_side.mag[l] = lane_p[l][CAND_W-1] ? MAG_W'(-lane_p[l])
                                                  : lane_p[l][MAG_W-1:0];
        end
        rad = r_a_best + MAG_W'(1 << FRAC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_rad  <= RAD_W'({rad, {FRAC{1'b0}}});
            r_b_side <= n_b_side;
        end
    end

    assign o_valid = r_b_vld;
    assign o_rad   = r_b_rad;
    assign o_side  = r_b_side;

endmodule

@@ src/rmq_sqrt.sv @@
// Pipelined integer square root, one root bit per stage, with sideband.
`timescale 1ns / 1ps
module rmq_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [rmq_pkg::RAD_W-1:0]   i_rad,
    input  rmq_pkg::t_side              i_side,
    output logic                        o_valid,
    output logic [rmq_pkg::ROOT_W-1:0]  o_root,
    output rmq_pkg::t_side              o_side
);
    import rmq_pkg::*;

    logic [SQ_STEPS-1:0] r_vld;
    logic [RAD_W-1:0]    r_rad  [SQ_STEPS];
    logic [SQ_REM_W-1:0] r_rem  [SQ_STEPS];
    logic [ROOT_W-1:0]   r_root [SQ_STEPS];
    t_side               r_side [SQ_STEPS];

    logic [RAD_W-1:0]    n_rad  [SQ_STEPS];
    logic [SQ_REM_W-1:0] n_rem  [SQ_STEPS];
    logic [ROOT_W-1:0]   n_root [SQ_STEPS];

    // Resolve one root digit per stage
    always_comb begin
        t_sq st;
        st        = sq_step('0, '0, i_rad[RAD_W-1 -: 2]);
        n_rad[0]  = i_rad << 2;
        n_rem[0]  = st.rem;
        n_root[0] = st.root;
        for (int k = 1; k < SQ_STEPS; k++) begin
            st        = sq_step(r_rem[k-1], r_root[k-1], r_rad[k-1][RAD_W-1 -: 2]);
            n_rad[k]  = r_rad[k-1] << 2;
            n_rem[k]  = st.rem;
            n_root[k] = st.root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[SQ_STEPS-2:0], i_valid};
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_rad[k]  <= n_rad[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
            for (int k = 1; k < SQ_STEPS; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_vld[SQ_STEPS-1];
    assign o_root  = r_root[SQ_STEPS-1];
    assign o_side  = r_side[SQ_STEPS-1];

endmodule

@@ src/rmq_div.sv @@
// Pipelined four-lane rounding divider: round(mag * 2^FRAC / den), one bit per stage.
`timescale 1ns / 1ps
module rmq_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [rmq_pkg::MAG_W-1:0]  i_den,
    input  rmq_pkg::t_side             i_side,
    output logic                       o_valid,
    output rmq_pkg::t_side             o_side
);
    import rmq_pkg::*;

    logic                 r_e_vld;
    logic [DVD_W-1:0]     r_e_d [LANES];
    logic [MAG_W-1:0]     r_e_den;
    t_side                r_e_side;

    logic [DIV_STEPS-1:0] r_vld;
    logic [MAG_W-1:0]     r_rem [DIV_STEPS][LANES];
    logic [MAG_W-1:0]     r_low [DIV_STEPS][LANES];
    logic [MAG_W-1:0]     r_q   [DIV_STEPS][LANES];
    logic [MAG_W-1:0]     r_den [DIV_STEPS];
    t_side                r_side [DIV_STEPS];

    logic [MAG_W-1:0]     n_rem [DIV_STEPS][LANES];
    logic [MAG_W-1:0]     n_low [DIV_STEPS][LANES];
    logic [MAG_W-1:0]     n_q   [DIV_STEPS][LANES];
    t_side                out_side;

    // Scale numerators and add half the divisor for rounding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (i_en) begin
            r_e_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES; l++) begin
                r_e_d[l] <= DVD_W'({i_side.mag[l], {FRAC{1'b0}}}) + DVD_W'(i_den >> 1);
            end
            r_e_den  <= i_den;
            r_e_side <= i_side;
        end
    end

    // Produce one quotient bit per stage and lane
    always_comb begin
        t_dv dv;
        for (int l = 0; l < LANES; l++) begin
            dv          = div_step(r_e_d[l][DVD_W-1 -: MAG_W], r_e_d[l][MAG_W-1], r_e_den);
            n_rem[0][l] = dv.rem;
            n_low[0][l] = r_e_d[l][MAG_W-1:0] << 1;
            n_q[0][l]   = MAG_W'(dv.q);
        end
        for (int k = 1; k < DIV_STEPS; k++) begin
            for (int l = 0; l < LANES; l++) begin
                dv          = div_step(r_rem[k-1][l], r_low[k-1][l][MAG_W-1], r_den[k-1]);
                n_rem[k][l] = dv.rem;
                n_low[k][l] = r_low[k-1][l] << 1;
                n_q[k][l]   = {r_q[k-1][l][MAG_W-2:0], dv.q};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STEPS-2:0], r_e_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]  <= r_e_den;
            r_side[0] <= r_e_side;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_den[k]  <= r_den[k-1];
                r_side[k] <= r_side[k-1];
            end
            for (int k = 0; k < DIV_STEPS; k++) begin
                for (int l = 0; l < LANES; l++) begin
                    r_rem[k][l] <= n_rem[k][l];
                    r_low[k][l] <= n_low[k][l];
                    r_q[k][l]   <= n_q[k][l];
                end
            end
        end
    end

    // Replace magnitudes with quotients, keep the rest of the sideband
    always_comb begin
        out_side = r_side[DIV_STEPS-1];
        for (int l = 0; l < LANES; l++) begin
            out_side.mag[l] = r_q[DIV_STEPS-1][l];
        end
    end

    assign o_valid = r_vld[DIV_STEPS-1];
    assign o_side  = out_side;

endmodule

@@ src/rmq_mid.sv @@
// Middle section: place components in w,x,y,z order, square and sum for the norm.
`timescale 1ns / 1ps
module rmq_mid (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  rmq_pkg::t_side            i_side,
    output logic                      o_valid,
    output logic [rmq_pkg::RAD_W-1:0] o_rad,
    output rmq_pkg::t_side            o_side
);
    import rmq_pkg::*;

    t_side            n1_side;
    logic [1:0]       lane;

    logic             r1_vld;
    t_side            r1_side;
    logic             r2_vld;
    t_side            r2_side;
    logic [RAD_W-1:0] r2_sq [LANES];
    logic             r3_vld;
    t_side            r3_side;
    logic [RAD_W-1:0] r3_sum;

    // Put the large component in its slot, the quotients around it
    always_comb begin
        n1_side     = i_side;
        n1_side.aux = '0;
        for (int j = 0; j < LANES; j++) begin
            lane = (2'(j) < i_side.sel) ? 2'(j) : 2'(j - 1);
            if (2'(j) == i_side.sel) begin
                n1_side.neg[j] = 1'b0;
                n1_side.mag[j] = i_side.aux;
            end else begin
                n1_side.neg[j] = i_side.neg[lane];
                n1_side.mag[j] = i_side.mag[lane];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    // Square, then sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side <= n1_side;
            r2_side <= r1_side;
            for (int l = 0; l < LANES; l++) begin
                r2_sq[l] <= RAD_W'(r1_side.mag[l]) * RAD_W'(r1_side.mag[l]);
            end
            r3_side <= r2_side;
            r3_sum  <= r2_sq[0] + r2_sq[1] + r2_sq[2] + r2_sq[3];
        end
    end

    assign o_valid = r3_vld;
    assign o_rad   = r3_sum;
    assign o_side  = r3_side;

endmodule

@@ src/rotation_matrix_to_quaternion.sv @@
// Throughput: one matrix per cycle unless the output stalls; two 17-stage square
// roots and two 18-stage dividers, one bit per stage, set the depth.
// A stall on the output freezes the whole pipeline, nothing is lost or repeated.
// Reset clears all valid bits at once; no other state.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_e_xx,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_e_xy,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_e_xz,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_e_yx,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_e_yy,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_e_yz,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_e_zx,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_e_zy,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_e_zz,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [rmq_pkg::DATA_W-1:0]  o_quat_w,
    output logic signed [rmq_pkg::DATA_W-1:0]  o_quat_x,
    output logic signed [rmq_pkg::DATA_W-1:0]  o_quat_y,
    output logic signed [rmq_pkg::DATA_W-1:0]  o_quat_z
);
    import rmq_pkg::*;

    localparam logic [MAG_W-1:0]  POS_MAX = MAG_W'((1 << (DATA_W - 1)) - 1);
    localparam logic [MAG_W-1:0]  NEG_MAX = MAG_W'(1 << (DATA_W - 1));

    logic              en;
    logic              fr_vld;
    logic [RAD_W-1:0]  fr_rad;
    t_side             fr_side;
    logic              s1_vld;
    logic [ROOT_W-1:0] s1_root;
    t_side             s1_side;
    logic [MAG_W-1:0]  big;
    logic [MAG_W-1:0]  den1;
    t_side             d1_in;
    logic              d1_vld;
    t_side             d1_side;
    logic              md_vld;
    logic [RAD_W-1:0]  md_rad;
    t_side             md_side;
    logic              s2_vld;
    logic [ROOT_W-1:0] s2_root;
    t_side             s2_side;
    logic              d2_vld;
    t_side             d2_side;
    logic signed [DATA_W-1:0] n_q [LANES];

    logic                     r_out_vld;
    logic signed [DATA_W-1:0] r_q [LANES];

    // Advance everything unless a held result is stalled
    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;

    rmq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_e_xx  (i_e_xx),
        .i_e_xy  (i_e_xy),
        .i_e_xz  (i_e_xz),
        .i_e_yx  (i_e_yx),
        .i_e_yy  (i_e_yy),
        .i_e_yz  (i_e_yz),
        .i_e_zx  (i_e_zx),
        .i_e_zy  (i_e_zy),
        .i_e_zz  (i_e_zz),
        .o_valid (fr_vld),
        .o_rad   (fr_rad),
        .o_side  (fr_side)
    );

    rmq_sqrt u_sqrt_big (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fr_vld),
        .i_rad   (fr_rad),
        .i_side  (fr_side),
        .o_valid (s1_vld),
        .o_root  (s1_root),
        .o_side  (s1_side)
    );

    // Large component is the rounded half root; divisor is four times it
    always_comb begin
        big       = MAG_W'((ROOT_W + 1)'(s1_root) + (ROOT_W + 1)'(1) >> 1);
        den1      = {big[MAG_W-3:0], 2'b00};
        d1_in     = s1_side;
        d1_in.aux = big;
    end

    rmq_div u_div_pair (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s1_vld),
        .i_den   (den1),
        .i_side  (d1_in),
        .o_valid (d1_vld),
        .o_side  (d1_side)
    );

    rmq_mid u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d1_vld),
        .i_side  (d1_side),
        .o_valid (md_vld),
        .o_rad   (md_rad),
        .o_side  (md_side)
    );

    rmq_sqrt u_sqrt_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (md_vld),
        .i_rad   (md_rad),
        .i_side  (md_side),
        .o_valid (s2_vld),
        .o_root  (s2_root),
        .o_side  (s2_side)
    );

    rmq_div u_div_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s2_vld),
        .i_den   (s2_root),
        .i_side  (s2_side),
        .o_valid (d2_vld),
        .o_side  (d2_side)
    );

    // Apply sign and saturate to the output format
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (d2_side.neg[l]) begin
                n_q[l] = (d2_side.mag[l] > NEG_MAX) ? DATA_W'(NEG_MAX)
                                                    : DATA_W'(-d2_side.mag[l]);
            end else begin
                n_q[l] = (d2_side.mag[l] > POS_MAX) ? DATA_W'(POS_MAX)
                                                    : d2_side.mag[l][DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= d2_vld;
        end
    end

    // Hold the result until its transfer
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                r_q[l] <= n_q[l];
            end
        end
    end

    assign o_valid  = r_out_vld;
    assign o_quat_w = r_q[0];
    assign o_quat_x = r_q[1];
    assign o_quat_y = r_q[2];
    assign o_quat_z = r_q[3];

endmodule
